FILE: rtl/pasm_pkg.sv
`timescale 1ns / 1ps

package pasm_pkg;

  // Operation codes held in the operation register. The unused code acts as multiply.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_SUB   = 2'd1;
  localparam logic [1:0] OP_MUL   = 2'd2;
  localparam logic [1:0] OP_RESET = OP_MUL;

  // Operand selector carried by every input item.
  localparam logic KIND_FIRST  = 1'b0;
  localparam logic KIND_SECOND = 1'b1;

  localparam int COEF_W = 32;
  localparam int POWER_W = 5;
  // Length fields of a job are sized for the largest supported store (32 entries).
  localparam int LEN_FIELD_W = 6;

  typedef struct packed {
    logic                     kind;
    logic signed [COEF_W-1:0] coefficient;
    logic                     final_coef;
  } in_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] result_coef;
    logic [POWER_W-1:0]       power;
    logic                     end_of_result;
    logic                     overflow;
  } out_item_t;

  // One loaded operand pair, handed from the loader to the arithmetic engine.
  typedef struct packed {
    logic                   bank;
    logic [LEN_FIELD_W-1:0] la;
    logic [LEN_FIELD_W-1:0] lb;
    logic [1:0]             op;
    logic                   dropped;
  } job_t;

endpackage

FILE: rtl/pasm_ram.sv
`timescale 1ns / 1ps

module pasm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/pasm_front.sv
`timescale 1ns / 1ps

module pasm_front #(
  parameter int MAX_DEGREE = 15
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  pasm_pkg::in_item_t                    in_data,
  input  logic [1:0]                            operation,
  output logic                                  we_first,
  output logic                                  we_second,
  output logic [$clog2(MAX_DEGREE + 1):0]       waddr,
  output logic [pasm_pkg::COEF_W-1:0]           wdata,
  output logic                                  push,
  output pasm_pkg::job_t                        push_job,
  input  logic                                  job_done
);

  localparam int STORE_DEPTH = MAX_DEGREE + 1;
  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int LEN_W = $clog2(STORE_DEPTH + 1);
  localparam int LFW = pasm_pkg::LEN_FIELD_W;

  logic [LEN_W-1:0] first_len_r, first_len_nxt;
  logic [LEN_W-1:0] second_len_r, second_len_nxt;
  logic             dropped_r, dropped_nxt;
  logic             bank_r;
  logic [1:0]       pend_r, pend_nxt;
  logic             accept, is_second, first_room, second_room;

  // Two banks per store: a new pair loads while the engine still works on the last one.
  assign in_stall    = (pend_r == 2'd2);
  assign accept      = in_valid && !in_stall;
  assign is_second   = (in_data.kind == pasm_pkg::KIND_SECOND);
  assign first_room  = (first_len_r < LEN_W'(STORE_DEPTH));
  assign second_room = (second_len_r < LEN_W'(STORE_DEPTH));

  assign we_first  = accept && !is_second && first_room;
  assign we_second = accept && is_second && second_room;
  assign waddr     = is_second ? {bank_r, second_len_r[IDX_W-1:0]}
                               : {bank_r, first_len_r[IDX_W-1:0]};
  assign wdata     = in_data.coefficient;

  assign push = accept && is_second && in_data.final_coef;

  always_comb begin
    first_len_nxt  = first_len_r;
    second_len_nxt = second_len_r;
    dropped_nxt    = dropped_r;
    if (accept) begin
      if (is_second) begin
        if (second_room) begin
          second_len_nxt = second_len_r + LEN_W'(1);
        end else begin
          dropped_nxt = 1'b1;
        end
      end else begin
        if (first_room) begin
          first_len_nxt = first_len_r + LEN_W'(1);
        end else begin
          dropped_nxt = 1'b1;
        end
      end
    end
  end

  assign push_job.bank    = bank_r;
  assign push_job.la      = LFW'(first_len_r);
  assign push_job.lb      = LFW'(second_len_nxt);
  assign push_job.op      = operation;
  assign push_job.dropped = dropped_nxt;

  always_comb begin
    pend_nxt = pend_r;
    if (push && !job_done) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!push && job_done) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_len_r  <= '0;
      second_len_r <= '0;
      dropped_r    <= 1'b0;
      bank_r       <= 1'b0;
      pend_r       <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
      if (push) begin
        first_len_r  <= '0;
        second_len_r <= '0;
        dropped_r    <= 1'b0;
        bank_r       <= !bank_r;
      end else begin
        first_len_r  <= first_len_nxt;
        second_len_r <= second_len_nxt;
        dropped_r    <= dropped_nxt;
      end
    end
  end

endmodule

FILE: rtl/pasm_queue.sv
`timescale 1ns / 1ps

module pasm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pasm_pkg::job_t push_job,
  input  logic           pop,
  output logic           q_valid,
  output pasm_pkg::job_t q_job
);

  // Two entries cover every job the loader can have outstanding.
  pasm_pkg::job_t ent_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;

  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push && pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/pasm_back.sv
`timescale 1ns / 1ps

module pasm_back #(
  parameter int MAX_DEGREE = 15,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  pasm_pkg::job_t                   q_job,
  output logic                             q_pop,
  output logic [$clog2(MAX_DEGREE + 1):0]  raddr_a,
  output logic [$clog2(MAX_DEGREE + 1):0]  raddr_b,
  input  logic [pasm_pkg::COEF_W-1:0]      rdata_a,
  input  logic [pasm_pkg::COEF_W-1:0]      rdata_b,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pasm_pkg::out_item_t              out_data,
  output logic                             job_done
);

  localparam int STORE_DEPTH = MAX_DEGREE + 1;
  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int LEN_W = $clog2(STORE_DEPTH + 1);
  localparam int RES_DEPTH = 2 * MAX_DEGREE + 1;
  localparam int RES_IDX_W = $clog2(RES_DEPTH);
  localparam int RES_LEN_W = $clog2(RES_DEPTH + 1);
  localparam int ACC_W = 64 + LEN_W + 1;
  localparam int PW = pasm_pkg::POWER_W;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'((2 ** FRAC_BITS) >> 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RUN, S_DRAIN, S_EMIT_RD, S_EMIT_LOAD, S_EMIT_OUT
  } state_t;

  state_t               state_r;
  logic                 bank_r, a_zero_r, b_zero_r, mul_r, sub_r;
  logic [LEN_W-1:0]     la_r, lb_r;
  logic [RES_LEN_W-1:0] n_full_r, e_n_r, nz_len_r;
  logic [RES_IDX_W-1:0] k_r, e_k_r;
  logic [IDX_W-1:0]     i_r, i_lo_r;
  logic                 out_valid_r, job_done_r, ov_r;
  pasm_pkg::out_item_t  out_data_r;

  // Job decode at start.
  logic [LEN_W-1:0]     la_raw, lb_raw, la_eff, lb_eff;
  logic                 job_mul;

  // Sequencer outputs.
  logic                 issue, iss_first, iss_last, iss_end, iss_a_use, iss_b_use;
  logic [IDX_W-1:0]     iss_a_idx, iss_b_idx, i_lo_next;
  logic [RES_IDX_W-1:0] j_full;
  logic [RES_LEN_W-1:0] k_len, kn;

  // Datapath stages.
  logic                        s1_v_r, s1_first_r, s1_last_r, s1_a_use_r, s1_b_use_r;
  logic [RES_IDX_W-1:0]        s1_k_r, s2_k_r, s3_k_r, s4_k_r;
  logic                        s2_v_r, s2_first_r, s2_last_r, s3_v_r, s4_v_r;
  logic signed [ACC_W-1:0]     s2_val_r, acc_r, rnd_r, shifted;
  logic signed [31:0]          a_s, b_s;
  logic signed [63:0]          prod;
  logic signed [32:0]          sum;
  logic                        fits;
  logic [31:0]                 res_wdata, res_rdata;
  logic                        emit_last;

  assign la_raw  = q_job.la[LEN_W-1:0];
  assign lb_raw  = q_job.lb[LEN_W-1:0];
  assign la_eff  = (la_raw == '0) ? LEN_W'(1) : la_raw;
  assign lb_eff  = (lb_raw == '0) ? LEN_W'(1) : lb_raw;
  assign job_mul = q_job.op[1];
  assign q_pop   = (state_r == S_IDLE) && q_valid;

  // Term sequencer: add and subtract take one term per degree, multiply walks
  // the pairs i + j = k that fall inside both operands.
  assign issue  = (state_r == S_RUN);
  assign k_len  = RES_LEN_W'(k_r);
  assign kn     = k_len + RES_LEN_W'(1);
  assign j_full = k_r - RES_IDX_W'(i_r);

  always_comb begin
    if (mul_r) begin
      iss_a_idx = i_r;
      iss_b_idx = j_full[IDX_W-1:0];
      iss_first = (i_r == i_lo_r);
      iss_last  = (RES_IDX_W'(i_r) == k_r) || (LEN_W'(i_r) == la_r - LEN_W'(1));
      iss_a_use = !a_zero_r;
      iss_b_use = !b_zero_r;
    end else begin
      iss_a_idx = k_r[IDX_W-1:0];
      iss_b_idx = k_r[IDX_W-1:0];
      iss_first = 1'b1;
      iss_last  = 1'b1;
      iss_a_use = !a_zero_r && (k_len < RES_LEN_W'(la_r));
      iss_b_use = !b_zero_r && (k_len < RES_LEN_W'(lb_r));
    end
  end

  assign iss_end   = iss_last && (kn == n_full_r);
  assign i_lo_next = (kn >= RES_LEN_W'(lb_r)) ?
                     IDX_W'(kn - RES_LEN_W'(lb_r) + RES_LEN_W'(1)) : '0;

  assign raddr_a = {bank_r, iss_a_idx};
  assign raddr_b = {bank_r, iss_b_idx};

  // Stage 2 operands; the read data lines up with the stage 1 registers.
  assign a_s  = s1_a_use_r ? rdata_a : '0;
  assign b_s  = s1_b_use_r ? rdata_b : '0;
  assign prod = a_s * b_s;
  assign sum  = sub_r ? ({a_s[31], a_s} - {b_s[31], b_s})
                      : ({a_s[31], a_s} + {b_s[31], b_s});

  // Stage 5: scale, saturate and write the result memory.
  assign shifted   = mul_r ? (rnd_r >>> FRAC_BITS) : rnd_r;
  assign fits      = (&shifted[ACC_W-1:31]) || !(|shifted[ACC_W-1:31]);
  assign res_wdata = fits ? shifted[31:0]
                          : (shifted[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  pasm_ram #(
    .WIDTH (32),
    .DEPTH (RES_DEPTH)
  ) u_result (
    .clk   (clk),
    .we    (s4_v_r),
    .waddr (s4_k_r),
    .wdata (res_wdata),
    .raddr (e_k_r),
    .rdata (res_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      ov_r     <= 1'b0;
      nz_len_r <= '0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r && s2_last_r;
      s4_v_r <= s3_v_r;
      if (q_pop) begin
        ov_r     <= q_job.dropped;
        nz_len_r <= '0;
      end else if (s4_v_r) begin
        if (!fits) begin
          ov_r <= 1'b1;
        end
        if (res_wdata != 32'd0) begin
          nz_len_r <= RES_LEN_W'(s4_k_r) + RES_LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= iss_first;
    s1_last_r  <= iss_last;
    s1_k_r     <= k_r;
    s1_a_use_r <= iss_a_use;
    s1_b_use_r <= iss_b_use;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_k_r     <= s1_k_r;
    s2_val_r   <= mul_r ? {{(ACC_W-64){prod[63]}}, prod} : {{(ACC_W-33){sum[32]}}, sum};
    if (s2_v_r) begin
      acc_r <= s2_first_r ? s2_val_r : acc_r + s2_val_r;
    end
    s3_k_r <= s2_k_r;
    rnd_r  <= acc_r + (mul_r ? HALF : '0);
    s4_k_r <= s3_k_r;
  end

  assign emit_last = ((RES_LEN_W'(e_k_r) + RES_LEN_W'(1)) == e_n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      job_done_r  <= 1'b0;
    end else begin
      job_done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            bank_r   <= q_job.bank;
            la_r     <= la_eff;
            lb_r     <= lb_eff;
            a_zero_r <= (la_raw == '0);
            b_zero_r <= (lb_raw == '0);
            mul_r    <= job_mul;
            sub_r    <= (q_job.op == pasm_pkg::OP_SUB);
            n_full_r <= job_mul
                        ? RES_LEN_W'(la_eff) + RES_LEN_W'(lb_eff) - RES_LEN_W'(1)
                        : RES_LEN_W'((la_eff > lb_eff) ? la_eff : lb_eff);
            k_r      <= '0;
            i_r      <= '0;
            i_lo_r   <= '0;
            state_r  <= S_RUN;
          end
        end
        S_RUN: begin
          if (iss_last) begin
            k_r    <= k_r + RES_IDX_W'(1);
            i_r    <= i_lo_next;
            i_lo_r <= i_lo_next;
          end else begin
            i_r <= i_r + IDX_W'(1);
          end
          if (iss_end) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!(s1_v_r || s2_v_r || s3_v_r || s4_v_r)) begin
            e_k_r   <= '0;
            e_n_r   <= sub_r ? ((nz_len_r == '0) ? RES_LEN_W'(1) : nz_len_r) : n_full_r;
            state_r <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state_r <= S_EMIT_LOAD;
        end
        S_EMIT_LOAD: begin
          out_data_r.result_coef   <= res_rdata;
          out_data_r.power         <= PW'(e_k_r);
          out_data_r.end_of_result <= emit_last;
          out_data_r.overflow      <= ov_r;
          out_valid_r              <= 1'b1;
          state_r                  <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_data_r.end_of_result) begin
              job_done_r <= 1'b1;
              state_r    <= S_IDLE;
            end else begin
              e_k_r   <= e_k_r + RES_IDX_W'(1);
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign job_done  = job_done_r;

endmodule

FILE: rtl/polynomial_add_sub_multiply.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake                      | Payload
// in_     | input     | in_valid / in_stall            | pasm_pkg::in_item_t (operand coefficient)
// out_    | output    | out_valid / out_stall          | pasm_pkg::out_item_t (result coefficient)
// cfg_    | input     | cfg_psel / cfg_penable / pready| operation register at byte address 0
//
// Coefficients are taken one per cycle. The loader stalls only while two operand pairs are
// outstanding, since each pair occupies one of the two store banks until its result is gone.
// The engine runs one job at a time: add and subtract walk max(la, lb) terms, multiply
// la * lb term pairs, bounded by the single shared 32x32 multiplier that performs one
// product per cycle. Each result transfer passes a read, a load and an output state for
// the result memory's registered read port, and out_stall holds it in the output state.
// Reset is synchronous and active low; the operation register resets to multiply, and no
// memory needs a clearing pass.

module polynomial_add_sub_multiply #(
  parameter int MAX_DEGREE = 15,
  parameter int FRAC_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  pasm_pkg::in_item_t  in_data,

  output logic                out_valid,
  input  logic                out_stall,
  output pasm_pkg::out_item_t out_data,

  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int STORE_DEPTH = MAX_DEGREE + 1;
  localparam int IDX_W = $clog2(STORE_DEPTH);
  // Each store holds two banks so that loading and computing overlap.
  localparam int BANKED_DEPTH = 2 ** (IDX_W + 1);
  localparam logic REG_OPERATION = 1'b0;

  logic [1:0]                operation_r;
  logic                      cfg_write;
  logic                      we_first, we_second;
  logic [IDX_W:0]            waddr, raddr_a, raddr_b;
  logic [31:0]               wdata, rdata_a, rdata_b;
  logic                      push, pop, q_valid, job_done;
  pasm_pkg::job_t            push_job, q_job;

  // The register is written in the access phase of a write transfer. The low two address
  // bits select bytes within the word and do not take part in decoding.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_OPERATION);
  assign cfg_prdata = (cfg_paddr[2] == REG_OPERATION) ? {30'd0, operation_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      operation_r <= pasm_pkg::OP_RESET;
    end else if (cfg_write) begin
      operation_r <= cfg_pwdata[1:0];
    end
  end

  // The loader fills the current bank and hands a job to the queue on the final
  // coefficient of the second operand. The operation is sampled at that moment.
  pasm_front #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .operation (operation_r),
    .we_first  (we_first),
    .we_second (we_second),
    .waddr     (waddr),
    .wdata     (wdata),
    .push      (push),
    .push_job  (push_job),
    .job_done  (job_done)
  );

  pasm_ram #(
    .WIDTH (32),
    .DEPTH (BANKED_DEPTH)
  ) u_first_store (
    .clk   (clk),
    .we    (we_first),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  pasm_ram #(
    .WIDTH (32),
    .DEPTH (BANKED_DEPTH)
  ) u_second_store (
    .clk   (clk),
    .we    (we_second),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  pasm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // The engine computes every result coefficient into its result memory first, because
  // the overflow mark and the trimmed length of a difference are known only at the end.
  pasm_back #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (pop),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .job_done  (job_done)
  );

endmodule

FILE: rtl/pasm_checker.sv
`timescale 1ns / 1ps

module pasm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input pasm_pkg::out_item_t out_data
);

  localparam int PW = pasm_pkg::POWER_W;

  logic [PW-1:0] exp_pow_r;
  logic          mid_r;
  logic          ov_hold_r;

  // Track the degree and overflow mark expected on the next result transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_pow_r <= '0;
      mid_r     <= 1'b0;
      ov_hold_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (out_data.end_of_result) begin
        exp_pow_r <= '0;
        mid_r     <= 1'b0;
      end else begin
        exp_pow_r <= exp_pow_r + PW'(1);
        mid_r     <= 1'b1;
        ov_hold_r <= out_data.overflow;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_power_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.power == exp_pow_r)
    else $error("result degree out of sequence");

  a_ov_const: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mid_r |-> out_data.overflow == ov_hold_r)
    else $error("overflow mark changed within one result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind polynomial_add_sub_multiply pasm_checker u_pasm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: test/tb_polynomial_add_sub_multiply.sv
`timescale 1ns / 1ps

module tb_polynomial_add_sub_multiply;

  // Block configuration under test. These match the defaults of the design.
  localparam int MAX_DEGREE  = 15;
  localparam int FRAC_BITS   = 16;
  localparam int STORE_DEPTH = MAX_DEGREE + 1;

  // The fourth operation code has no name in the package; the block treats it as multiply.
  localparam logic [1:0] OP_SPARE       = 2'd3;
  localparam logic [2:0] OPERATION_ADDR = 3'd0;

  localparam int RANDOM_ITEMS     = 470;
  // Cycles allowed after the last expected coefficient before touching the register.
  // Nothing is in flight once every result has left, so a short margin is enough.
  localparam int SETTLE_CYCLES    = 40;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT      = 1000000;

  // Stall patterns used by the result side.
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

  // Keeps a private copy of both operand stores and the operation register, and turns
  // every accepted coefficient into the result coefficients the block must produce.
  class poly_scoreboard #(int DEPTH = 16, int FRAC = 16);
    logic signed [31:0]  first_coefs[DEPTH];
    logic signed [31:0]  second_coefs[DEPTH];
    int                  first_len;
    int                  second_len;
    bit                  dropped;
    bit                  saturated;
    logic [1:0]          operation = pasm_pkg::OP_RESET;
    pasm_pkg::out_item_t expected_coefs[$];
    int                  errors;
    int                  checked;
    int                  flagged;
    int                  op_count[4];

    function logic signed [31:0] clamp_coef(logic signed [127:0] v);
      if (v > 128'sd2147483647) begin
        saturated = 1'b1;
        return 32'sh7FFFFFFF;
      end
      if (v < -128'sd2147483648) begin
        saturated = 1'b1;
        return 32'sh80000000;
      end
      return v[31:0];
    endfunction

    // Runs the configured operation on the loaded operands and queues its result.
    function void run_operation();
      logic signed [31:0]  a[DEPTH];
      logic signed [31:0]  b[DEPTH];
      logic signed [31:0]  r[2*DEPTH-1];
      logic signed [127:0] x;
      logic signed [127:0] y;
      logic signed [127:0] acc;
      int                  la;
      int                  lb;
      int                  n;
      pasm_pkg::out_item_t e;
      a = first_coefs;
      b = second_coefs;
      la = first_len;
      lb = second_len;
      // An operand with no coefficients is the zero polynomial.
      if (la == 0) begin
        a[0] = '0;
        la = 1;
      end
      if (lb == 0) begin
        b[0] = '0;
        lb = 1;
      end
      saturated = dropped;
      op_count[operation]++;
      if (operation == pasm_pkg::OP_ADD || operation == pasm_pkg::OP_SUB) begin
        n = (la > lb) ? la : lb;
        for (int k = 0; k < n; k++) begin
          x = '0;
          y = '0;
          if (k < la) x = a[k];
          if (k < lb) y = b[k];
          r[k] = clamp_coef((operation == pasm_pkg::OP_ADD) ? x + y : x - y);
        end
        // A difference loses its zero top coefficients, but never its last one.
        if (operation == pasm_pkg::OP_SUB) begin
          while (n > 1 && r[n-1] == 0) n--;
        end
      end else begin
        n = la + lb - 1;
        for (int k = 0; k < n; k++) begin
          acc = '0;
          for (int i = 0; i < la && i <= k; i++) begin
            if (k - i < lb) acc = acc + a[i] * b[k-i];
          end
          if (FRAC > 0) acc = (acc + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
          r[k] = clamp_coef(acc);
        end
      end
      for (int k = 0; k < n; k++) begin
        e.result_coef   = r[k];
        e.power         = k[pasm_pkg::POWER_W-1:0];
        e.end_of_result = (k == n - 1);
        e.overflow      = saturated;
        expected_coefs  = {expected_coefs, e};
        if (saturated) flagged++;
      end
      first_len = 0;
      second_len = 0;
      dropped = 1'b0;
    endfunction

    function void note_coefficient(pasm_pkg::in_item_t it);
      if (it.kind == pasm_pkg::KIND_FIRST) begin
        if (first_len < DEPTH) begin
          first_coefs[first_len] = it.coefficient;
          first_len++;
        end else begin
          dropped = 1'b1;
        end
      end else begin
        if (second_len < DEPTH) begin
          second_coefs[second_len] = it.coefficient;
          second_len++;
        end else begin
          dropped = 1'b1;
        end
        // Even a dropped final coefficient starts the operation.
        if (it.final_coef) run_operation();
      end
    endfunction

    function void check_result_coef(pasm_pkg::out_item_t got);
      pasm_pkg::out_item_t want;
      if (expected_coefs.size() == 0) begin
        $display("%0t: unexpected result coefficient, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_coefs.pop_front();
      checked++;
      if (got.result_coef !== want.result_coef) begin
        $display("%0t: coefficient of power %0d expected %h actual %h", $time, want.power,
                 want.result_coef, got.result_coef);
        errors++;
      end
      if (got.power !== want.power) begin
        $display("%0t: power expected %0d actual %0d", $time, want.power, got.power);
        errors++;
      end
      if (got.end_of_result !== want.end_of_result) begin
        $display("%0t: end mark at power %0d expected %b actual %b", $time, want.power,
                 want.end_of_result, got.end_of_result);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow at power %0d expected %b actual %b", $time, want.power,
                 want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  pasm_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  pasm_pkg::out_item_t out_data;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [2:0]          cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  poly_scoreboard #(STORE_DEPTH, FRAC_BITS) sb;

  int cycle_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  int phases_run = 0;
  // Raised once by the stimulus; the result side then holds off on its own count.
  bit hold_go = 1'b0;

  polynomial_add_sub_multiply #(
    .MAX_DEGREE(MAX_DEGREE),
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #2 clk = ~clk;

  // Watchdog. A hung handshake or a result that never shows up ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result monitor. Outputs are sampled at the rising edge, before the block updates them,
  // and out_stall only ever changes at the falling edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_result_coef(out_data);
  end

  // Result side. It switches between stall patterns, including long stretches with no
  // stall at all, and once performs a long hold so that both store banks fill up and the
  // loader has to stall the input channel.
  initial begin
    rx_pattern_t pattern;
    int          pattern_left;
    int          hold_left;
    bit          hold_done;
    pattern = RX_FREE;
    pattern_left = 100;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (pattern_left == 0) begin
        pattern = rx_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(20, 200);
      end
      pattern_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (pattern)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
          RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:  out_stall <= ((cycle_count % 7) < 3);
        endcase
      end
    end
  end

  // Drops in_valid for an idle gap of length n. The next transfer raises it again at a later falling
  // edge, so valid never gets two assignments in one time step.
  task automatic idle_input(int n);
    if (n <= 0) return;
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // The sender works in bursts; between bursts it inserts a random gap, which is
  // sometimes zero so that long back-to-back stretches occur as well.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      idle_input(gap);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // Offers one coefficient and holds it until the transfer completes. in_valid is left
  // high; the caller either offers the next coefficient or idles the channel.
  task automatic send_coef(logic kind, logic [31:0] coef, logic fin);
    pasm_pkg::in_item_t it;
    pace();
    it.kind = kind;
    it.coefficient = coef;
    it.final_coef = fin;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_coefficient(it);
    items_sent++;
  endtask

  // Stops offering and waits until every predicted coefficient has been transferred.
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_coefs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_operation_reg(logic [1:0] want);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= OPERATION_ADDR;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== 32'(want)) begin
      $display("%0t: operation register expected %h actual %h", $time, 32'(want), cfg_prdata);
      sb.errors++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // The register is only written with the block idle: no result outstanding, no job running.
  task automatic write_operation(logic [1:0] op);
    wait_results_drained();
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= OPERATION_ADDR;
    cfg_pwdata <= 32'(op);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.operation = op;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    check_operation_reg(op);
    phases_run++;
  endtask

  // Mostly short operands keep multiplies fast; now and then the stores are filled, and
  // sometimes overfilled so that coefficients get dropped.
  function automatic int pick_length(int min_len);
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(min_len, 5);
    if (r < 17) return $urandom_range(6, STORE_DEPTH);
    return $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 3);
  endfunction

  // A mix of saturating extremes, zero, full 32-bit patterns and moderate Q16.16 values.
  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2:       return '0;
      3, 4:    return $urandom();
      default: return $urandom_range(0, 32'h001FFFFF) - 32'h00100000;
    endcase
  endfunction

  // Sends one operand pair ending in the final coefficient of the second polynomial.
  // Most pairs are clean; some interleave the two operands, and the first operand
  // sometimes carries a final mark, which the block must ignore.
  task automatic send_pair(logic [1:0] op);
    logic [31:0] a[$];
    logic [31:0] b[$];
    int          la;
    int          lb;
    int          ia;
    int          ib;
    bit          mixed;
    logic        fin;
    la = pick_length(0);
    lb = pick_length(1);
    for (int i = 0; i < la; i++) a = {a, rand_coef()};
    // Matching top coefficients make a subtraction trim its zero tail.
    for (int i = 0; i < lb; i++) begin
      if (op == pasm_pkg::OP_SUB && i < la && $urandom_range(0, 1) == 1) b = {b, a[i]};
      else b = {b, rand_coef()};
    end
    mixed = ($urandom_range(0, 5) == 0);
    ia = 0;
    ib = 0;
    while (ia < la || ib < lb - 1) begin
      if (ia < la && (ib >= lb - 1 || !mixed || $urandom_range(0, 1) == 1)) begin
        fin = (ia == la - 1) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 7) == 0);
        send_coef(pasm_pkg::KIND_FIRST, a[ia], fin);
        ia++;
      end else begin
        send_coef(pasm_pkg::KIND_SECOND, b[ib], 1'b0);
        ib++;
      end
    end
    send_coef(pasm_pkg::KIND_SECOND, b[lb-1], 1'b1);
  endtask

  initial begin
    int         directed_items;
    int         phase;
    int         phase_target;
    logic [1:0] op;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The operation register comes out of reset as multiply.
    check_operation_reg(pasm_pkg::OP_RESET);

    // Directed part, multiply: the most negative value squared saturates, an empty first
    // operand acts as zero, and a final mark on the first operand changes nothing.
    send_coef(pasm_pkg::KIND_FIRST, 32'h80000000, 1'b0);
    send_coef(pasm_pkg::KIND_SECOND, 32'h80000000, 1'b1);
    send_coef(pasm_pkg::KIND_SECOND, 32'h7FFFFFFF, 1'b1);
    send_coef(pasm_pkg::KIND_FIRST, 32'h00010000, 1'b0);
    send_coef(pasm_pkg::KIND_FIRST, 32'hFFFF8000, 1'b1);
    send_coef(pasm_pkg::KIND_SECOND, 32'h7FFFFFFF, 1'b0);
    send_coef(pasm_pkg::KIND_SECOND, 32'h00018000, 1'b1);

    // Add: saturation at both ends, and a longer first operand padded on the second side.
    write_operation(pasm_pkg::OP_ADD);
    send_coef(pasm_pkg::KIND_FIRST, 32'h7FFFFFFF, 1'b0);
    send_coef(pasm_pkg::KIND_SECOND, 32'h7FFFFFFF, 1'b1);
    send_coef(pasm_pkg::KIND_FIRST, 32'h80000000, 1'b0);
    send_coef(pasm_pkg::KIND_FIRST, 32'h00000001, 1'b0);
    send_coef(pasm_pkg::KIND_FIRST, 32'hFFFFFFFF, 1'b0);
    send_coef(pasm_pkg::KIND_SECOND, 32'h80000000, 1'b1);

    // Subtract: a cancelled top coefficient is trimmed, zero minus zero keeps one
    // coefficient, and the negative end saturates.
    write_operation(pasm_pkg::OP_SUB);
    send_coef(pasm_pkg::KIND_FIRST, 32'h00010000, 1'b0);
    send_coef(pasm_pkg::KIND_FIRST, 32'h00050000, 1'b0);
    send_coef(pasm_pkg::KIND_SECOND, 32'h00000000, 1'b0);
    send_coef(pasm_pkg::KIND_SECOND, 32'h00050000, 1'b1);
    send_coef(pasm_pkg::KIND_SECOND, 32'h00000000, 1'b1);
    send_coef(pasm_pkg::KIND_FIRST, 32'h80000000, 1'b0);
    send_coef(pasm_pkg::KIND_SECOND, 32'h00000001, 1'b1);

    // The unused operation code must behave as multiply.
    write_operation(OP_SPARE);
    send_coef(pasm_pkg::KIND_FIRST, 32'h00030000, 1'b0);
    send_coef(pasm_pkg::KIND_FIRST, 32'hFFFE0000, 1'b0);
    send_coef(pasm_pkg::KIND_SECOND, 32'h00040000, 1'b0);
    send_coef(pasm_pkg::KIND_SECOND, 32'h00050000, 1'b1);
    directed_items = items_sent;

    // Random part. Each phase drains the block, sets an operation and streams operand
    // pairs. The first phases walk through every code, later ones pick at random.
    phase = 0;
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      case (phase)
        0:       op = pasm_pkg::OP_ADD;
        1:       op = pasm_pkg::OP_SUB;
        2:       op = pasm_pkg::OP_MUL;
        3:       op = OP_SPARE;
        default: op = $urandom_range(0, 3);
      endcase
      write_operation(op);
      // During the first multiply phase the result side holds off for a long time while
      // the sender keeps going, which fills both banks and forces in_stall.
      if (phase == 2) begin
        @(posedge clk);
        hold_go = 1'b1;
      end
      phase_target = items_sent + $urandom_range(30, 90);
      if (phase_target > directed_items + RANDOM_ITEMS) begin
        phase_target = directed_items + RANDOM_ITEMS;
      end
      while (items_sent < phase_target) send_pair(op);
      phase++;
    end

    wait_results_drained();
    $display("Sent %0d transfers in %0d phases: %0d adds, %0d subtracts, %0d multiplies.",
             items_sent, phases_run, sb.op_count[pasm_pkg::OP_ADD],
             sb.op_count[pasm_pkg::OP_SUB],
             sb.op_count[pasm_pkg::OP_MUL] + sb.op_count[OP_SPARE]);
    $display("Checked %0d result coefficients, %0d of them flagged as overflowed.",
             sb.checked, sb.flagged);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
